/* rtl/core/padsr_pkg.sv */
package padsr_pkg;

   localparam int VOICES_DEFAULT          = 8;
   localparam int SINE_TABLE_BITS_DEFAULT = 10;
   localparam int PHASE_BITS_DEFAULT      = 24;

   localparam int FULL_SCALE = 8388608;

   localparam logic [1:0] FUNC_TICK     = 2'd0;
   localparam logic [1:0] FUNC_NOTE_ON  = 2'd1;
   localparam logic [1:0] FUNC_NOTE_OFF = 2'd2;
   localparam logic [1:0] FUNC_RESERVED = 2'd3;

   localparam logic [1:0] CSR_ATTACK_STEP   = 2'd0;
   localparam logic [1:0] CSR_DECAY_STEP    = 2'd1;
   localparam logic [1:0] CSR_SUSTAIN_LEVEL = 2'd2;
   localparam logic [1:0] CSR_RELEASE_RATE  = 2'd3;

   localparam logic [23:0] ATTACK_STEP_RESET   = 24'd19022;
   localparam logic [23:0] DECAY_STEP_RESET    = 24'd571;
   localparam logic [23:0] SUSTAIN_LEVEL_RESET = 24'd5872026;
   localparam logic [23:0] RELEASE_RATE_RESET  = 24'd1902;

   localparam logic [2:0] STAGE_ATTACK  = 3'd0;
   localparam logic [2:0] STAGE_DECAY   = 3'd1;
   localparam logic [2:0] STAGE_SUSTAIN = 3'd2;
   localparam logic [2:0] STAGE_RELEASE = 3'd3;
   localparam logic [2:0] STAGE_OFF     = 3'd4;

   typedef struct packed {
      logic [1:0]  func;
      logic [23:0] freq_step;
      logic [15:0] amplitude;
   } req_type;

   typedef struct packed {
      logic signed [23:0] sample;
      logic               voices_full;
      logic [3:0]         slots_used;
   } rsp_type;

   typedef enum logic [4:0] {
      S_IDLE, S_DECODE, S_NOTE_ON, S_OFF_RD, S_OFF_MUL, S_OFF_WR,
      S_T_RD, S_T_ENV, S_T_SKIP, S_MXX, S_X2, S_MR, S_HR, S_MXR,
      S_SINE, S_MLA, S_GAIN, S_MGS, S_ACC, S_DIV_INIT, S_DIV, S_DIV_END,
      S_RESULT
   } ctrl_state_type;

   typedef enum logic [4:0] {
      OP_NONE, OP_LATCH, OP_NOTE_ON, OP_READ_LAST, OP_OFF_MUL, OP_OFF_WR,
      OP_READ_VOICE, OP_ENV, OP_NEXT, OP_MUL_XX, OP_X2, OP_MUL_X2R,
      OP_HORNER, OP_MUL_XR, OP_SINE, OP_MUL_LA, OP_GAIN, OP_MUL_GS,
      OP_ACC, OP_DIV_INIT, OP_DIV_STEP, OP_DIV_END, OP_RESULT
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
   } cmd_type;

   typedef struct packed {
      logic [1:0] func;
      logic       slot_full;
      logic       slot_zero;
      logic       voice_off;
      logic       last_voice;
      logic       iter_zero;
      logic       live_zero;
   } status_type;

   function automatic logic signed [32:0] taylor_coef(input logic [2:0] k);
      logic signed [32:0] c;
      case (k)
         3'd0:    c = 33'sd1686629713;
         3'd1:    c = 33'sd693598668;
         3'd2:    c = 33'sd85569306;
         3'd3:    c = 33'sd5026995;
         3'd4:    c = 33'sd172273;
         default: c = 33'sd3864;
      endcase
      return c;
   endfunction

endpackage

/* rtl/core/polyphonic_adsr_sine_synth.sv */
// Channel   Direction  Handshake             Payload
// req_      in         req_valid/req_stall   padsr_pkg::req_type (func, freq_step, amplitude)
// rsp_      out        rsp_valid/rsp_stall   padsr_pkg::rsp_type (sample, voices_full, slots_used)
// csr_      in         csr_wr_en             csr_index, csr_wr_data
//
// One item is worked at a time; a shared 33x33 multiplier and a voice RAM set the pace.
// A tick walks every used voice slot, skipping voices that are off, and ends in a final
// one-bit-per-cycle divide that runs DIV_W = 25 + clog2(VOICES + 1) steps when a voice is live.
// Reset is synchronous; voice RAM entries are read only after a note-on has written them.
// A stalled result holds the block in its output state until the transfer completes.
module polyphonic_adsr_sine_synth #(
   parameter int VOICES          = padsr_pkg::VOICES_DEFAULT,
   parameter int SINE_TABLE_BITS = padsr_pkg::SINE_TABLE_BITS_DEFAULT,
   parameter int PHASE_BITS      = padsr_pkg::PHASE_BITS_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  padsr_pkg::req_type req_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output padsr_pkg::rsp_type rsp_data,
   input  logic               csr_wr_en,
   input  logic [1:0]         csr_index,
   input  logic [23:0]        csr_wr_data
);

   padsr_pkg::cmd_type    cmd;
   padsr_pkg::status_type status;

   padsr_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .status   (status),
      .cmd      (cmd)
   );

   padsr_dp #(
      .VOICES         (VOICES),
      .SINE_TABLE_BITS(SINE_TABLE_BITS),
      .PHASE_BITS     (PHASE_BITS)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_data   (req_data),
      .rsp_data   (rsp_data),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wr_data(csr_wr_data),
      .cmd        (cmd),
      .status     (status)
   );

endmodule

/* rtl/core/padsr_ram.sv */
module padsr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8
) (
   input  logic                                      clock,
   input  logic                                      wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                          wr_data,
   input  logic                                      rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                          rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/core/padsr_ctrl.sv */
module padsr_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  padsr_pkg::status_type status,
   output padsr_pkg::cmd_type    cmd
);

   padsr_pkg::ctrl_state_type state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic rsp_free;

   assign rsp_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         padsr_pkg::S_IDLE:
            if (req_valid) state_in = padsr_pkg::S_DECODE;
         padsr_pkg::S_DECODE: begin
            unique case (status.func)
               padsr_pkg::FUNC_TICK:
                  state_in = status.slot_zero ? padsr_pkg::S_DIV_INIT : padsr_pkg::S_T_RD;
               padsr_pkg::FUNC_NOTE_ON:
                  state_in = padsr_pkg::S_NOTE_ON;
               padsr_pkg::FUNC_NOTE_OFF:
                  state_in = status.slot_zero ? padsr_pkg::S_RESULT : padsr_pkg::S_OFF_RD;
               default:
                  state_in = padsr_pkg::S_RESULT;
            endcase
         end
         padsr_pkg::S_NOTE_ON:  state_in = padsr_pkg::S_RESULT;
         padsr_pkg::S_OFF_RD:   state_in = padsr_pkg::S_OFF_MUL;
         padsr_pkg::S_OFF_MUL:  state_in = padsr_pkg::S_OFF_WR;
         padsr_pkg::S_OFF_WR:   state_in = padsr_pkg::S_RESULT;
         padsr_pkg::S_T_RD:     state_in = padsr_pkg::S_T_ENV;
         padsr_pkg::S_T_ENV: begin
            if (!status.voice_off) state_in = padsr_pkg::S_MXX;
            else if (status.last_voice) state_in = padsr_pkg::S_DIV_INIT;
            else state_in = padsr_pkg::S_T_SKIP;
         end
         padsr_pkg::S_T_SKIP:   state_in = padsr_pkg::S_T_RD;
         padsr_pkg::S_MXX:      state_in = padsr_pkg::S_X2;
         padsr_pkg::S_X2:       state_in = padsr_pkg::S_MR;
         padsr_pkg::S_MR:       state_in = padsr_pkg::S_HR;
         padsr_pkg::S_HR:
            state_in = status.iter_zero ? padsr_pkg::S_MXR : padsr_pkg::S_MR;
         padsr_pkg::S_MXR:      state_in = padsr_pkg::S_SINE;
         padsr_pkg::S_SINE:     state_in = padsr_pkg::S_MLA;
         padsr_pkg::S_MLA:      state_in = padsr_pkg::S_GAIN;
         padsr_pkg::S_GAIN:     state_in = padsr_pkg::S_MGS;
         padsr_pkg::S_MGS:      state_in = padsr_pkg::S_ACC;
         padsr_pkg::S_ACC:
            state_in = status.last_voice ? padsr_pkg::S_DIV_INIT : padsr_pkg::S_T_RD;
         padsr_pkg::S_DIV_INIT:
            state_in = status.live_zero ? padsr_pkg::S_RESULT : padsr_pkg::S_DIV;
         padsr_pkg::S_DIV:
            if (status.iter_zero) state_in = padsr_pkg::S_DIV_END;
         padsr_pkg::S_DIV_END:  state_in = padsr_pkg::S_RESULT;
         padsr_pkg::S_RESULT:
            if (rsp_free) state_in = padsr_pkg::S_IDLE;
         default:               state_in = padsr_pkg::S_IDLE;
      endcase
   end

   always_comb begin
      cmd.op = padsr_pkg::OP_NONE;
      req_stall = 1'b1;
      unique case (state_ff)
         padsr_pkg::S_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) cmd.op = padsr_pkg::OP_LATCH;
         end
         padsr_pkg::S_NOTE_ON:  cmd.op = padsr_pkg::OP_NOTE_ON;
         padsr_pkg::S_OFF_RD:   cmd.op = padsr_pkg::OP_READ_LAST;
         padsr_pkg::S_OFF_MUL:  cmd.op = padsr_pkg::OP_OFF_MUL;
         padsr_pkg::S_OFF_WR:   cmd.op = padsr_pkg::OP_OFF_WR;
         padsr_pkg::S_T_RD:     cmd.op = padsr_pkg::OP_READ_VOICE;
         padsr_pkg::S_T_ENV:    cmd.op = padsr_pkg::OP_ENV;
         padsr_pkg::S_T_SKIP:   cmd.op = padsr_pkg::OP_NEXT;
         padsr_pkg::S_MXX:      cmd.op = padsr_pkg::OP_MUL_XX;
         padsr_pkg::S_X2:       cmd.op = padsr_pkg::OP_X2;
         padsr_pkg::S_MR:       cmd.op = padsr_pkg::OP_MUL_X2R;
         padsr_pkg::S_HR:       cmd.op = padsr_pkg::OP_HORNER;
         padsr_pkg::S_MXR:      cmd.op = padsr_pkg::OP_MUL_XR;
         padsr_pkg::S_SINE:     cmd.op = padsr_pkg::OP_SINE;
         padsr_pkg::S_MLA:      cmd.op = padsr_pkg::OP_MUL_LA;
         padsr_pkg::S_GAIN:     cmd.op = padsr_pkg::OP_GAIN;
         padsr_pkg::S_MGS:      cmd.op = padsr_pkg::OP_MUL_GS;
         padsr_pkg::S_ACC:      cmd.op = padsr_pkg::OP_ACC;
         padsr_pkg::S_DIV_INIT: cmd.op = padsr_pkg::OP_DIV_INIT;
         padsr_pkg::S_DIV:      cmd.op = padsr_pkg::OP_DIV_STEP;
         padsr_pkg::S_DIV_END:  cmd.op = padsr_pkg::OP_DIV_END;
         padsr_pkg::S_RESULT:
            if (rsp_free) cmd.op = padsr_pkg::OP_RESULT;
         default:               cmd.op = padsr_pkg::OP_NONE;
      endcase
   end

   always_comb begin
      if (state_ff == padsr_pkg::S_RESULT && rsp_free) rsp_valid_in = 1'b1;
      else rsp_valid_in = rsp_valid_ff && rsp_stall;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= padsr_pkg::S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

/* rtl/core/padsr_dp.sv */
module padsr_dp #(
   parameter int VOICES          = padsr_pkg::VOICES_DEFAULT,
   parameter int SINE_TABLE_BITS = padsr_pkg::SINE_TABLE_BITS_DEFAULT,
   parameter int PHASE_BITS      = padsr_pkg::PHASE_BITS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  padsr_pkg::req_type    req_data,
   output padsr_pkg::rsp_type    rsp_data,
   input  logic                  csr_wr_en,
   input  logic [1:0]            csr_index,
   input  logic [23:0]           csr_wr_data,
   input  padsr_pkg::cmd_type    cmd,
   output padsr_pkg::status_type status
);

   localparam int P       = PHASE_BITS;
   localparam int AW      = VOICES > 1 ? $clog2(VOICES) : 1;
   localparam int CNT_W   = $clog2(VOICES + 1);
   localparam int AMP_LO  = 0;
   localparam int INC_LO  = 16;
   localparam int PH_LO   = 16 + P;
   localparam int STEP_LO = 16 + 2 * P;
   localparam int LVL_LO  = 40 + 2 * P;
   localparam int STG_LO  = 64 + 2 * P;
   localparam int REC_W   = 67 + 2 * P;
   localparam int SUM_W   = 48 + CNT_W;
   localparam int DIV_W   = SUM_W - 23;
   localparam int ITW     = $clog2(DIV_W) + 1;
   localparam int XSH     = 32 - SINE_TABLE_BITS;

   logic [23:0] attack_ff, decay_ff, sustain_ff, release_ff;
   padsr_pkg::req_type req_ff;
   logic [CNT_W-1:0] slot_ff, v_ff, live_ff, rem_ff;
   logic [ITW-1:0]   iter_ff;
   logic [2:0]       stg_ff;
   logic [23:0]      lvl_ff, stp_ff;
   logic [P-1:0]     ph_ff, inc_ff;
   logic [15:0]      amp_ff;
   logic [30:0]      x_ff, x2_ff;
   logic             neg_ff;
   logic signed [32:0] r_ff;
   logic [24:0]        gain_ff;
   logic signed [23:0] sine_ff;
   logic signed [63:0] prod_ff;
   logic signed [SUM_W-1:0] sum_ff;
   logic [DIV_W-1:0]   dvd_ff;
   logic               sneg_ff;
   logic signed [23:0] sample_ff;
   logic               full_ff;
   padsr_pkg::rsp_type rsp_ff;

   logic [CNT_W-1:0] slot_m1;
   logic             ram_we, ram_re;
   logic [AW-1:0]    ram_waddr, ram_raddr;
   logic [REC_W-1:0] ram_wdata, ram_rdata;
   logic [2:0]       rd_stg;
   logic [23:0]      rd_lvl, rd_stp;
   logic [P-1:0]     rd_ph, rd_inc;
   logic [15:0]      rd_amp;
   logic [P+23:0]    fwide;
   logic [P-1:0]     new_inc;
   logic [23:0]      sus;
   logic [24:0]      att_sum;
   logic signed [25:0] dec_diff;
   logic [2:0]       env_stg;
   logic [23:0]      env_lvl, env_stp;
   logic [SINE_TABLE_BITS-1:0] idx;
   logic [29:0]      xq;
   logic [30:0]      xv;
   logic signed [32:0] mul_a, mul_b;
   logic signed [65:0] mul_p;
   logic [48:0]      rel_sum;
   logic signed [32:0] q30, sround;
   logic signed [23:0] sine_v;
   logic [SUM_W-1:0] sum_abs;
   logic [CNT_W:0]   dtrial;
   logic             dge;
   logic [CNT_W+3:0] slot_ext;

   assign slot_m1 = slot_ff - CNT_W'(1);

   assign rd_stg = ram_rdata[STG_LO +: 3];
   assign rd_lvl = ram_rdata[LVL_LO +: 24];
   assign rd_stp = ram_rdata[STEP_LO +: 24];
   assign rd_ph  = ram_rdata[PH_LO +: P];
   assign rd_inc = ram_rdata[INC_LO +: P];
   assign rd_amp = ram_rdata[AMP_LO +: 16];

   assign fwide   = {req_ff.freq_step, P'(0)};
   assign new_inc = fwide[P+23:24];

   assign sus = (sustain_ff > 24'(padsr_pkg::FULL_SCALE)) ?
                24'(padsr_pkg::FULL_SCALE) : sustain_ff;
   assign att_sum  = {1'b0, rd_lvl} + {1'b0, rd_stp};
   assign dec_diff = $signed({2'b00, rd_lvl}) - $signed({2'b00, rd_stp});

   always_comb begin
      env_stg = rd_stg;
      env_lvl = rd_lvl;
      env_stp = rd_stp;
      case (rd_stg)
         padsr_pkg::STAGE_ATTACK: begin
            if (att_sum >= 25'(padsr_pkg::FULL_SCALE)) begin
               env_lvl = 24'(padsr_pkg::FULL_SCALE);
               env_stg = padsr_pkg::STAGE_DECAY;
               env_stp = decay_ff;
            end else begin
               env_lvl = att_sum[23:0];
            end
         end
         padsr_pkg::STAGE_DECAY: begin
            if (dec_diff <= $signed({2'b00, sus})) begin
               env_lvl = sus;
               env_stg = padsr_pkg::STAGE_SUSTAIN;
            end else begin
               env_lvl = dec_diff[23:0];
            end
         end
         padsr_pkg::STAGE_RELEASE: begin
            if (dec_diff <= 26'sd0) begin
               env_lvl = 24'd0;
               env_stg = padsr_pkg::STAGE_OFF;
            end else begin
               env_lvl = dec_diff[23:0];
            end
         end
         default: begin
         end
      endcase
   end

   assign idx = rd_ph[P-1 -: SINE_TABLE_BITS];
   assign xq  = 30'(idx[SINE_TABLE_BITS-3:0]) << XSH;
   assign xv  = idx[SINE_TABLE_BITS-2] ? (31'h40000000 - {1'b0, xq}) : {1'b0, xq};

   always_comb begin
      mul_a = 33'sd0;
      mul_b = 33'sd0;
      case (cmd.op)
         padsr_pkg::OP_MUL_XX: begin
            mul_a = $signed({2'b00, x_ff});
            mul_b = $signed({2'b00, x_ff});
         end
         padsr_pkg::OP_MUL_X2R: begin
            mul_a = $signed({2'b00, x2_ff});
            mul_b = r_ff;
         end
         padsr_pkg::OP_MUL_XR: begin
            mul_a = $signed({2'b00, x_ff});
            mul_b = r_ff;
         end
         padsr_pkg::OP_MUL_LA: begin
            mul_a = $signed({9'd0, lvl_ff});
            mul_b = $signed({17'd0, amp_ff});
         end
         padsr_pkg::OP_MUL_GS: begin
            mul_a = $signed({8'd0, gain_ff});
            mul_b = 33'(sine_ff);
         end
         padsr_pkg::OP_OFF_MUL: begin
            mul_a = $signed({9'd0, rd_lvl});
            mul_b = $signed({9'd0, release_ff});
         end
         default: begin
         end
      endcase
   end

   assign mul_p = mul_a * mul_b;

   assign rel_sum = {1'b0, prod_ff[47:0]} + 49'hFFFFFF;
   assign q30     = $signed(prod_ff[62:30]);
   assign sround  = (q30 + 33'sd64) >>> 7;

   always_comb begin
      if (sround > 33'sd8388607) sine_v = 24'sd8388607;
      else sine_v = sround[23:0];
      if (neg_ff) sine_v = -sine_v;
   end

   assign sum_abs = sum_ff[SUM_W-1] ? SUM_W'(-sum_ff) : SUM_W'(sum_ff);
   assign dtrial  = {rem_ff, dvd_ff[DIV_W-1]};
   assign dge     = dtrial >= {1'b0, live_ff};

   always_comb begin
      ram_we    = 1'b0;
      ram_waddr = v_ff[AW-1:0];
      ram_wdata = {stg_ff, lvl_ff, stp_ff, P'(ph_ff + inc_ff), inc_ff, amp_ff};
      ram_re    = 1'b0;
      ram_raddr = v_ff[AW-1:0];
      case (cmd.op)
         padsr_pkg::OP_NOTE_ON: begin
            ram_we    = !status.slot_full;
            ram_waddr = slot_ff[AW-1:0];
            ram_wdata = {padsr_pkg::STAGE_ATTACK, 24'd0, attack_ff, P'(0), new_inc,
                         req_ff.amplitude};
         end
         padsr_pkg::OP_OFF_WR: begin
            ram_we    = 1'b1;
            ram_waddr = slot_m1[AW-1:0];
            ram_wdata = {padsr_pkg::STAGE_RELEASE, rd_lvl, rel_sum[47:24], rd_ph, rd_inc,
                         rd_amp};
         end
         padsr_pkg::OP_ACC:       ram_we = 1'b1;
         padsr_pkg::OP_READ_VOICE: ram_re = 1'b1;
         padsr_pkg::OP_READ_LAST: begin
            ram_re    = 1'b1;
            ram_raddr = slot_m1[AW-1:0];
         end
         default: begin
         end
      endcase
   end

   padsr_ram #(
      .WIDTH(REC_W),
      .DEPTH(VOICES)
   ) u_voice_ram (
      .clock  (clock),
      .wr_en  (ram_we),
      .wr_addr(ram_waddr),
      .wr_data(ram_wdata),
      .rd_en  (ram_re),
      .rd_addr(ram_raddr),
      .rd_data(ram_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         attack_ff  <= padsr_pkg::ATTACK_STEP_RESET;
         decay_ff   <= padsr_pkg::DECAY_STEP_RESET;
         sustain_ff <= padsr_pkg::SUSTAIN_LEVEL_RESET;
         release_ff <= padsr_pkg::RELEASE_RATE_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            padsr_pkg::CSR_ATTACK_STEP:   attack_ff  <= csr_wr_data;
            padsr_pkg::CSR_DECAY_STEP:    decay_ff   <= csr_wr_data;
            padsr_pkg::CSR_SUSTAIN_LEVEL: sustain_ff <= csr_wr_data;
            padsr_pkg::CSR_RELEASE_RATE:  release_ff <= csr_wr_data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff <= '0;
      end else if (cmd.op == padsr_pkg::OP_NOTE_ON && !status.slot_full) begin
         slot_ff <= slot_ff + CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= mul_p[63:0];
      case (cmd.op)
         padsr_pkg::OP_LATCH: begin
            req_ff    <= req_data;
            v_ff      <= '0;
            live_ff   <= '0;
            sum_ff    <= '0;
            sample_ff <= '0;
            full_ff   <= 1'b0;
         end
         padsr_pkg::OP_NOTE_ON:
            if (status.slot_full) full_ff <= 1'b1;
         padsr_pkg::OP_ENV: begin
            stg_ff <= env_stg;
            lvl_ff <= env_lvl;
            stp_ff <= env_stp;
            ph_ff  <= rd_ph;
            inc_ff <= rd_inc;
            amp_ff <= rd_amp;
            x_ff   <= xv;
            neg_ff <= idx[SINE_TABLE_BITS-1];
         end
         padsr_pkg::OP_NEXT:
            v_ff <= v_ff + CNT_W'(1);
         padsr_pkg::OP_X2: begin
            x2_ff   <= prod_ff[60:30];
            r_ff    <= padsr_pkg::taylor_coef(3'd5);
            iter_ff <= ITW'(4);
         end
         padsr_pkg::OP_HORNER: begin
            r_ff    <= padsr_pkg::taylor_coef(iter_ff[2:0]) - q30;
            iter_ff <= iter_ff - ITW'(1);
         end
         padsr_pkg::OP_SINE:
            sine_ff <= sine_v;
         padsr_pkg::OP_GAIN:
            gain_ff <= prod_ff[40:16];
         padsr_pkg::OP_ACC: begin
            sum_ff  <= sum_ff + $signed(prod_ff[SUM_W-1:0]);
            live_ff <= live_ff + CNT_W'(1);
            v_ff    <= v_ff + CNT_W'(1);
         end
         padsr_pkg::OP_DIV_INIT: begin
            dvd_ff  <= sum_abs[SUM_W-1:23];
            sneg_ff <= sum_ff[SUM_W-1];
            rem_ff  <= '0;
            iter_ff <= ITW'(DIV_W - 1);
         end
         padsr_pkg::OP_DIV_STEP: begin
            rem_ff  <= dge ? CNT_W'(dtrial - {1'b0, live_ff}) : dtrial[CNT_W-1:0];
            dvd_ff  <= {dvd_ff[DIV_W-2:0], dge};
            iter_ff <= iter_ff - ITW'(1);
         end
         padsr_pkg::OP_DIV_END: begin
            if (!sneg_ff) begin
               sample_ff <= (dvd_ff > DIV_W'(8388607)) ? 24'sd8388607 :
                            $signed(dvd_ff[23:0]);
            end else begin
               sample_ff <= (dvd_ff > DIV_W'(8388608)) ? -24'sd8388608 :
                            -$signed(dvd_ff[23:0]);
            end
         end
         padsr_pkg::OP_RESULT: begin
            rsp_ff.sample      <= sample_ff;
            rsp_ff.voices_full <= full_ff;
            rsp_ff.slots_used  <= slot_ext[3:0];
         end
         default: begin
         end
      endcase
   end

   assign slot_ext = {4'd0, slot_ff};

   assign status.func       = req_ff.func;
   assign status.slot_full  = slot_ff == CNT_W'(VOICES);
   assign status.slot_zero  = slot_ff == '0;
   assign status.voice_off  = rd_stg >= padsr_pkg::STAGE_OFF;
   assign status.last_voice = v_ff == slot_m1;
   assign status.iter_zero  = iter_ff == '0;
   assign status.live_zero  = live_ff == '0;

   assign rsp_data = rsp_ff;

endmodule
